// File: rtl/tilt_angle_from_imu_core_defines.svh
// assertion helpers used by the core rtl
`ifndef TILT_ANGLE_FROM_IMU_CORE_DEFINES_SVH
`define TILT_ANGLE_FROM_IMU_CORE_DEFINES_SVH

// same-cycle implication
`define TAFI_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define TAFI_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/tafi_pkg.sv
package tafi_pkg;

   localparam int CORDIC_STEPS = 16;
   localparam int ATAN_ENTRIES = 24;
   localparam int CORDIC_ITERS = (CORDIC_STEPS > ATAN_ENTRIES) ? ATAN_ENTRIES : CORDIC_STEPS;

   localparam int SQRT_W = 62;
   localparam int ROOT_W = SQRT_W / 2;
   localparam int CX_W   = 34;
   localparam int Z_W    = 25;
   localparam int ACC_W  = 24;
   localparam int SQ_W   = 45;
   localparam int MUL_W  = 27;
   localparam int PROD_W = 2 * MUL_W;

   localparam int TILT_LIMIT     = 11520;
   localparam int TILT_HALF_TURN = 23040;

   // accel: floor((raw*624 + 5) / 10), biased positive, reciprocal 2^29/10
   localparam int ACC_SCALE  = 624;
   localparam int ACC_BIAS   = 5 + 10 * 4194304;
   localparam int ACC_UNBIAS = 4194304;
   localparam int RECIP10    = 53687092;
   // rate: floor((raw*56 + 25) / 50), reciprocal 2^29/50
   localparam int RATE_SCALE  = 56;
   localparam int RATE_BIAS   = 25 + 50 * 65536;
   localparam int RATE_UNBIAS = 65536;
   localparam int RECIP50     = 10737419;
   localparam int RECIP_SHIFT = 29;

   typedef enum logic [1:0] {
      CSR_OFFSET_X = 2'd0,
      CSR_OFFSET_Y = 2'd1,
      CSR_OFFSET_Z = 2'd2,
      CSR_PERIOD   = 2'd3
   } csr_index_type;

   typedef enum logic [4:0] {
      ST_IDLE, ST_M_AX, ST_M_AY, ST_M_AZ, ST_M_RX, ST_M_RY,
      ST_D_AX, ST_D_AY, ST_D_AZ, ST_D_RX, ST_D_RY,
      ST_SQ_X, ST_SQ_Y, ST_SQ_Z, ST_I_X, ST_I_Y, ST_I_END,
      ST_RY_GO, ST_RY_WAIT, ST_CY_GO, ST_CY_WAIT,
      ST_RX_GO, ST_RX_WAIT, ST_CX_GO, ST_CX_WAIT, ST_FOLD
   } state_type;

   function automatic logic [22:0] atan_entry(input logic [4:0] idx);
      logic [22:0] v;
      case (idx)
         5'd0:  v = 23'd2949120;
         5'd1:  v = 23'd1740967;
         5'd2:  v = 23'd919879;
         5'd3:  v = 23'd466945;
         5'd4:  v = 23'd234379;
         5'd5:  v = 23'd117304;
         5'd6:  v = 23'd58666;
         5'd7:  v = 23'd29335;
         5'd8:  v = 23'd14668;
         5'd9:  v = 23'd7334;
         5'd10: v = 23'd3667;
         5'd11: v = 23'd1833;
         5'd12: v = 23'd917;
         5'd13: v = 23'd458;
         5'd14: v = 23'd229;
         5'd15: v = 23'd115;
         5'd16: v = 23'd57;
         5'd17: v = 23'd29;
         5'd18: v = 23'd14;
         5'd19: v = 23'd7;
         5'd20: v = 23'd4;
         5'd21: v = 23'd2;
         5'd22: v = 23'd1;
         default: v = 23'd0;
      endcase
      return v;
   endfunction

endpackage

// File: rtl/tafi_isqrt.sv
module tafi_isqrt (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [tafi_pkg::SQRT_W-1:0]   value,
   output logic                          done,
   output logic [tafi_pkg::ROOT_W-1:0]   root
);
   import tafi_pkg::*;

   localparam int REM_W = ROOT_W + 3;

   logic [SQRT_W-1:0] val_ff;
   logic [REM_W-1:0]  rem_ff, rem_in, rem_sh, trial;
   logic [ROOT_W-1:0] root_ff, root_in;
   logic [4:0]        cnt_ff;
   logic              busy_ff;

   // one result bit per cycle, two radicand bits brought down
   always_comb begin
      rem_sh = {rem_ff[REM_W-3:0], val_ff[SQRT_W-1:SQRT_W-2]};
      trial  = {1'b0, root_ff, 2'b01};
      if (rem_sh >= trial) begin
         rem_in  = rem_sh - trial;
         root_in = {root_ff[ROOT_W-2:0], 1'b1};
      end else begin
         rem_in  = rem_sh;
         root_in = {root_ff[ROOT_W-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         cnt_ff  <= '0;
      end else if (busy_ff) begin
         cnt_ff <= cnt_ff + 5'd1;
         if (cnt_ff == 5'(ROOT_W - 1)) busy_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         val_ff  <= value;
         rem_ff  <= '0;
         root_ff <= '0;
      end else if (busy_ff) begin
         val_ff  <= {val_ff[SQRT_W-3:0], 2'b00};
         rem_ff  <= rem_in;
         root_ff <= root_in;
      end
   end

   assign done = busy_ff && (cnt_ff == 5'(ROOT_W - 1));
   assign root = root_ff;

endmodule

// File: rtl/tafi_cordic.sv
module tafi_cordic (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic signed [tafi_pkg::ACC_W-1:0] num,
   input  logic [tafi_pkg::ROOT_W-1:0]   den,
   output logic                          done,
   output logic signed [15:0]            tilt
);
   import tafi_pkg::*;

   logic signed [CX_W-1:0] x_ff, y_ff, dx, dy;
   logic signed [Z_W-1:0]  z_ff, ang, zr;
   logic [4:0]             cnt_ff;
   logic                   busy_ff, done_ff, zero_ff, lim_ff, neg_ff;

   always_comb begin
      dx  = y_ff >>> cnt_ff;
      dy  = x_ff >>> cnt_ff;
      ang = Z_W'(atan_entry(cnt_ff));
      zr  = (z_ff + Z_W'(256)) >>> 9;
      if (zero_ff) begin
         tilt = '0;
      end else if (lim_ff) begin
         tilt = neg_ff ? -16'(TILT_LIMIT) : 16'(TILT_LIMIT);
      end else if (zr > Z_W'(TILT_LIMIT)) begin
         tilt = 16'(TILT_LIMIT);
      end else if (zr < -Z_W'(TILT_LIMIT)) begin
         tilt = -16'(TILT_LIMIT);
      end else begin
         tilt = 16'(zr);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (start) begin
         busy_ff <= !(num == '0 || den == '0);
         done_ff <= (num == '0 || den == '0);
         cnt_ff  <= '0;
      end else if (busy_ff) begin
         cnt_ff <= cnt_ff + 5'd1;
         if (cnt_ff == 5'(CORDIC_ITERS - 1)) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end else begin
         done_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         x_ff    <= CX_W'(den);
         y_ff    <= CX_W'(num) <<< 8;
         z_ff    <= '0;
         zero_ff <= (num == '0);
         lim_ff  <= (den == '0);
         neg_ff  <= num[ACC_W-1];
      end else if (busy_ff) begin
         // rotate towards the x axis
         if (!y_ff[CX_W-1]) begin
            x_ff <= x_ff + dx;
            y_ff <= y_ff - dy;
            z_ff <= z_ff + ang;
         end else begin
            x_ff <= x_ff - dx;
            y_ff <= y_ff + dy;
            z_ff <= z_ff - ang;
         end
      end
   end

   assign done = done_ff;

endmodule

// File: rtl/tilt_angle_from_imu_core.sv
// channel   dir  handshake              payload
// req       in   req_tvalid/req_tready  req_tdata[79:0]: raw accel x,y,z, gyro x,y
// rsp       out  rsp_tvalid/rsp_tready  rsp_tdata[135:0]: tilts, rates, gyro angles
// csr       in   csr_valid/csr_ready    csr_index[1:0], csr_data[15:0]
// a word holds the block from accept to the next ready, set by the bit-serial square root and
// cordic loops, each run once per tilt; no new word is taken before the last one is finished
// a tilt with a zero numerator or zero root skips its cordic loop
// one shared multiplier does scaling, division by reciprocal, squares and integration
// reset is synchronous; offsets and period return to their defaults, accumulators to zero
// req_tready is high only while idle; a finished word waits in the fold state while the
// output register holds an untaken word
module tilt_angle_from_imu_core (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // accel_x_raw, accel_y_raw, accel_z_raw, gyro_x_raw, gyro_y_raw
   input  logic [79:0]  req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // tilt_x, tilt_y, rate_x, rate_y, gyro_angle_x, gyro_angle_y, zero fill
   output logic [135:0] rsp_tdata,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [1:0]   csr_index,
   input  logic [15:0]  csr_data
);
   import tafi_pkg::*;
   `include "tilt_angle_from_imu_core_defines.svh"

   state_type state_ff, state_in;

   logic signed [15:0] raw_ax_ff, raw_ay_ff, raw_az_ff, raw_gx_ff, raw_gy_ff;
   logic signed [15:0] off_x_ff, off_y_ff, off_z_ff;
   logic [15:0]        period_ff;

   logic signed [MUL_W-1:0]  mul_a, mul_b;
   logic signed [PROD_W-1:0] p_ff;

   logic signed [MUL_W-1:0] nx_ff, ny_ff, nz_ff, nrx_ff, nry_ff;
   logic signed [ACC_W-1:0] ax_ff, ay_ff, az_ff;
   logic signed [16:0]      rx_ff, ry_ff;
   logic [SQ_W-1:0]         sqx_ff, sqy_ff, sqz_ff;
   logic signed [31:0]      acc_x_ff, acc_y_ff, acc_sat;
   logic signed [15:0]      tx_ff, ty_ff;

   logic signed [ACC_W+1:0] acc_conv;
   logic signed [16:0]      rate_conv;
   logic signed [33:0]      delta;
   logic signed [34:0]      acc_sum;
   logic signed [31:0]      acc_sel;

   logic                    sqrt_start, sqrt_done, cor_start, cor_done;
   logic [SQRT_W-1:0]       sqrt_val;
   logic [ROOT_W-1:0]       root;
   logic signed [ACC_W-1:0] cor_num;
   logic signed [15:0]      cor_tilt;

   logic signed [16:0] abs_tx, abs_ty, m_x, m_y, fold_x, fold_y;
   logic signed [15:0] fin_x, fin_y;

   logic         out_valid_ff;
   logic [135:0] out_data_ff;
   logic         out_free;

   assign out_free   = !out_valid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;
   assign csr_ready  = 1'b1;

   // ---------------- next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:    if (req_tvalid) state_in = ST_M_AX;
         ST_M_AX:    state_in = ST_M_AY;
         ST_M_AY:    state_in = ST_M_AZ;
         ST_M_AZ:    state_in = ST_M_RX;
         ST_M_RX:    state_in = ST_M_RY;
         ST_M_RY:    state_in = ST_D_AX;
         ST_D_AX:    state_in = ST_D_AY;
         ST_D_AY:    state_in = ST_D_AZ;
         ST_D_AZ:    state_in = ST_D_RX;
         ST_D_RX:    state_in = ST_D_RY;
         ST_D_RY:    state_in = ST_SQ_X;
         ST_SQ_X:    state_in = ST_SQ_Y;
         ST_SQ_Y:    state_in = ST_SQ_Z;
         ST_SQ_Z:    state_in = ST_I_X;
         ST_I_X:     state_in = ST_I_Y;
         ST_I_Y:     state_in = ST_I_END;
         ST_I_END:   state_in = ST_RY_GO;
         ST_RY_GO:   state_in = ST_RY_WAIT;
         ST_RY_WAIT: if (sqrt_done) state_in = ST_CY_GO;
         ST_CY_GO:   state_in = ST_CY_WAIT;
         ST_CY_WAIT: if (cor_done) state_in = ST_RX_GO;
         ST_RX_GO:   state_in = ST_RX_WAIT;
         ST_RX_WAIT: if (sqrt_done) state_in = ST_CX_GO;
         ST_CX_GO:   state_in = ST_CX_WAIT;
         ST_CX_WAIT: if (cor_done) state_in = ST_FOLD;
         ST_FOLD:    if (out_free) state_in = ST_IDLE;
         default:    state_in = ST_IDLE;
      endcase
   end

   // ---------------- unit controls
   always_comb begin
      mul_a      = '0;
      mul_b      = '0;
      sqrt_start = 1'b0;
      cor_start  = 1'b0;
      sqrt_val   = SQRT_W'({sqz_ff + sqy_ff, 16'd0});
      cor_num    = ax_ff;
      case (state_ff)
         ST_M_AX: begin mul_a = -MUL_W'(raw_ax_ff); mul_b = MUL_W'(ACC_SCALE); end
         ST_M_AY: begin mul_a = MUL_W'(raw_ay_ff);  mul_b = MUL_W'(ACC_SCALE); end
         ST_M_AZ: begin mul_a = MUL_W'(raw_az_ff);  mul_b = MUL_W'(ACC_SCALE); end
         ST_M_RX: begin mul_a = MUL_W'(raw_gx_ff);  mul_b = MUL_W'(RATE_SCALE); end
         ST_M_RY: begin mul_a = MUL_W'(raw_gy_ff);  mul_b = MUL_W'(RATE_SCALE); end
         ST_D_AX: begin mul_a = nx_ff;  mul_b = MUL_W'(RECIP10); end
         ST_D_AY: begin mul_a = ny_ff;  mul_b = MUL_W'(RECIP10); end
         ST_D_AZ: begin mul_a = nz_ff;  mul_b = MUL_W'(RECIP10); end
         ST_D_RX: begin mul_a = nrx_ff; mul_b = MUL_W'(RECIP50); end
         ST_D_RY: begin mul_a = nry_ff; mul_b = MUL_W'(RECIP50); end
         ST_SQ_X: begin mul_a = MUL_W'(ax_ff); mul_b = MUL_W'(ax_ff); end
         ST_SQ_Y: begin mul_a = MUL_W'(ay_ff); mul_b = MUL_W'(ay_ff); end
         ST_SQ_Z: begin mul_a = MUL_W'(az_ff); mul_b = MUL_W'(az_ff); end
         ST_I_X:  begin mul_a = MUL_W'(rx_ff); mul_b = MUL_W'({1'b0, period_ff}); end
         ST_I_Y:  begin mul_a = MUL_W'(ry_ff); mul_b = MUL_W'({1'b0, period_ff}); end
         ST_RY_GO: sqrt_start = 1'b1;
         ST_CY_GO: cor_start = 1'b1;
         ST_RX_GO: begin
            sqrt_start = 1'b1;
            sqrt_val   = SQRT_W'({sqz_ff + sqx_ff, 16'd0});
         end
         ST_CX_GO: begin
            cor_start = 1'b1;
            cor_num   = ay_ff;
         end
         default: ;
      endcase
   end

   // ---------------- datapath helpers
   always_comb begin
      acc_conv  = $signed({2'b00, p_ff[RECIP_SHIFT+ACC_W-1:RECIP_SHIFT]})
                  - (ACC_W+2)'(ACC_UNBIAS);
      rate_conv = 17'($signed({1'b0, p_ff[RECIP_SHIFT+23:RECIP_SHIFT]})
                  - 25'(RATE_UNBIAS));
      delta     = ($signed(p_ff[33:0]) + 34'sd8) >>> 4;
      acc_sel   = (state_ff == ST_I_Y) ? acc_x_ff : acc_y_ff;
      acc_sum   = 35'(acc_sel) + 35'(delta);
      if (acc_sum > 35'sh7FFFFFFF) begin
         acc_sat = 32'sh7FFFFFFF;
      end else if (acc_sum < -35'sh80000000) begin
         acc_sat = 32'sh80000000;
      end else begin
         acc_sat = 32'(acc_sum);
      end
   end

   // fold past the quarter turn when z points down
   always_comb begin
      abs_tx = tx_ff[15] ? -17'(tx_ff) : 17'(tx_ff);
      abs_ty = ty_ff[15] ? -17'(ty_ff) : 17'(ty_ff);
      m_y    = 17'(TILT_HALF_TURN) - (abs_tx <<< 1);
      m_x    = 17'(TILT_HALF_TURN) - (abs_ty <<< 1);
      fold_y = ty_ff[15] ? (-17'(ty_ff) - m_y) : (m_y - 17'(ty_ff));
      fold_x = tx_ff[15] ? (-17'(tx_ff) - m_x) : (m_x - 17'(tx_ff));
      fin_x  = az_ff[ACC_W-1] ? 16'(fold_x) : tx_ff;
      fin_y  = az_ff[ACC_W-1] ? 16'(fold_y) : ty_ff;
   end

   // ---------------- registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         off_x_ff  <= 16'sd985;
         off_y_ff  <= 16'sd221;
         off_z_ff  <= 16'sd1615;
         period_ff <= 16'd1311;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_OFFSET_X: off_x_ff  <= csr_data;
            CSR_OFFSET_Y: off_y_ff  <= csr_data;
            CSR_OFFSET_Z: off_z_ff  <= csr_data;
            CSR_PERIOD:   period_ff <= csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_x_ff <= '0;
         acc_y_ff <= '0;
      end else if (state_ff == ST_I_Y) begin
         acc_x_ff <= acc_sat;
      end else if (state_ff == ST_I_END) begin
         acc_y_ff <= acc_sat;
      end
   end

   always_ff @(posedge clock) begin
      p_ff <= mul_a * mul_b;
      case (state_ff)
         ST_IDLE: begin
            raw_ax_ff <= req_tdata[15:0];
            raw_ay_ff <= req_tdata[31:16];
            raw_az_ff <= req_tdata[47:32];
            raw_gx_ff <= req_tdata[63:48];
            raw_gy_ff <= req_tdata[79:64];
         end
         ST_M_AY: nx_ff  <= MUL_W'(p_ff) + MUL_W'(ACC_BIAS);
         ST_M_AZ: ny_ff  <= MUL_W'(p_ff) + MUL_W'(ACC_BIAS);
         ST_M_RX: nz_ff  <= MUL_W'(p_ff) + MUL_W'(ACC_BIAS);
         ST_M_RY: nrx_ff <= MUL_W'(p_ff) + MUL_W'(RATE_BIAS);
         ST_D_AX: nry_ff <= MUL_W'(p_ff) + MUL_W'(RATE_BIAS);
         ST_D_AY: ax_ff  <= ACC_W'(acc_conv + (ACC_W+2)'(off_x_ff));
         ST_D_AZ: ay_ff  <= ACC_W'(acc_conv + (ACC_W+2)'(off_y_ff));
         ST_D_RX: az_ff  <= ACC_W'(acc_conv + (ACC_W+2)'(off_z_ff));
         ST_D_RY: rx_ff  <= rate_conv;
         ST_SQ_X: ry_ff  <= rate_conv;
         ST_SQ_Y: sqx_ff <= p_ff[SQ_W-1:0];
         ST_SQ_Z: sqy_ff <= p_ff[SQ_W-1:0];
         ST_I_X:  sqz_ff <= p_ff[SQ_W-1:0];
         ST_CY_WAIT: if (cor_done) ty_ff <= cor_tilt;
         ST_CX_WAIT: if (cor_done) tx_ff <= cor_tilt;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (state_ff == ST_FOLD && out_free) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_FOLD && out_free) begin
         out_data_ff <= {6'd0, acc_y_ff, acc_x_ff, ry_ff, rx_ff, fin_y, fin_x};
      end
   end

   tafi_isqrt u_isqrt (
      .clock (clock),
      .reset (reset),
      .start (sqrt_start),
      .value (sqrt_val),
      .done  (sqrt_done),
      .root  (root)
   );

   tafi_cordic u_cordic (
      .clock (clock),
      .reset (reset),
      .start (cor_start),
      .num   (cor_num),
      .den   (root),
      .done  (cor_done),
      .tilt  (cor_tilt)
   );

   `TAFI_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_tvalid && req_tready, !req_tready,
      "input accepted while a word is in flight")
   `TAFI_ASSERT_NEXT(a_acc_x_only_in_update, clock, reset, state_ff != ST_I_Y,
      $stable(acc_x_ff), "gyro x angle moved outside its update step")
   `TAFI_ASSERT_NEXT(a_zero_period_holds, clock, reset,
      state_ff == ST_I_Y && period_ff == 16'd0, $stable(acc_x_ff),
      "gyro x angle moved with zero period")
   `TAFI_ASSERT_NOW(a_fold_waits, clock, reset,
      state_ff == ST_FOLD && out_valid_ff && !rsp_tready, state_in == ST_FOLD,
      "result overwrote an untaken word")

endmodule

// File: tb/tilt_angle_from_imu_core_test.sv
`timescale 1ns / 1ps

module tilt_angle_from_imu_core_test;
   import tafi_pkg::*;

   typedef struct packed {
      logic signed [31:0] angle_y;
      logic signed [31:0] angle_x;
      logic signed [16:0] rate_y;
      logic signed [16:0] rate_x;
      logic signed [15:0] tilt_y;
      logic signed [15:0] tilt_x;
   } imu_result_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   // accel_x_raw, accel_y_raw, accel_z_raw, gyro_x_raw, gyro_y_raw
   logic [79:0]  req_tdata = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   // tilt_x, tilt_y, rate_x, rate_y, gyro_angle_x, gyro_angle_y, zero fill
   logic [135:0] rsp_tdata;
   logic         csr_valid = 1'b0;
   logic         csr_ready;
   logic [1:0]   csr_index = '0;
   logic [15:0]  csr_data = '0;

   tilt_angle_from_imu_core DUT (.*);

   // predictor state
   longint ofs_x, ofs_y, ofs_z, period;
   longint acc_x, acc_y;
   imu_result_type expected_words[$];
   int mismatches = 0;
   int send_idle = 0;
   int recv_stall = 0;
   int hold_off = 0;

   localparam longint ATAN_TABLE[24] = '{2949120, 1740967, 919879, 466945, 234379, 117304,
      58666, 29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7, 4, 2, 1, 0};

   initial forever #4 clock = ~clock;

   function automatic longint fdiv(longint p, longint d);
      if (p >= 0) return p / d;
      return -((-p + d - 1) / d);
   endfunction

   function automatic longint isqrt(longint n);
      longint r, b;
      r = 0;
      b = 64'sd1 <<< 62;
      while (b > n) b = b >>> 2;
      while (b != 0) begin
         if (n >= r + b) begin
            n = n - (r + b);
            r = (r >>> 1) + b;
         end else begin
            r = r >>> 1;
         end
         b = b >>> 2;
      end
      return r;
   endfunction

   function automatic longint tilt_angle(longint a, longint b, longint c);
      longint x, y, z, dx, dy, r;
      int steps;
      if (b < 0) b = -b;
      if (c < 0) c = -c;
      x = isqrt((b * b + c * c) <<< 16);
      y = a * 256;
      z = 0;
      if (a == 0) return 0;
      if (x == 0) return a > 0 ? TILT_LIMIT : -TILT_LIMIT;
      steps = CORDIC_STEPS > 24 ? 24 : CORDIC_STEPS;
      for (int i = 0; i < steps; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (y >= 0) begin
            x += dx; y -= dy; z += ATAN_TABLE[i];
         end else begin
            x -= dx; y += dy; z -= ATAN_TABLE[i];
         end
      end
      r = fdiv(z + 256, 512);
      if (r > TILT_LIMIT) r = TILT_LIMIT;
      if (r < -TILT_LIMIT) r = -TILT_LIMIT;
      return r;
   endfunction

   function automatic longint fold_tilt(longint t, longint other);
      longint m;
      m = TILT_HALF_TURN - 2 * (other < 0 ? -other : other);
      return t < 0 ? -t - m : m - t;
   endfunction

   function automatic longint integrate_rate(longint acc, longint rate);
      longint s;
      s = acc + fdiv(rate * period + 8, 16);
      if (s > 64'sd2147483647) s = 64'sd2147483647;
      if (s < -64'sd2147483648) s = -64'sd2147483648;
      return s;
   endfunction

   function automatic imu_result_type predict_sample(logic [79:0] d);
      longint ax, ay, az, rx, ry, tx, ty, nx;
      imu_result_type r;
      ax = fdiv(2 * (-longint'($signed(d[15:0])) * 312) + 5, 10) + ofs_x;
      ay = fdiv(2 * (longint'($signed(d[31:16])) * 312) + 5, 10) + ofs_y;
      az = fdiv(2 * (longint'($signed(d[47:32])) * 312) + 5, 10) + ofs_z;
      rx = fdiv(2 * (longint'($signed(d[63:48])) * 28) + 25, 50);
      ry = fdiv(2 * (longint'($signed(d[79:64])) * 28) + 25, 50);
      ty = tilt_angle(ax, az, ay);
      tx = tilt_angle(ay, az, ax);
      if (az < 0) begin
         nx = fold_tilt(tx, ty);
         ty = fold_tilt(ty, tx);
         tx = nx;
      end
      acc_x = integrate_rate(acc_x, rx);
      acc_y = integrate_rate(acc_y, ry);
      r.tilt_x = tx[15:0];
      r.tilt_y = ty[15:0];
      r.rate_x = rx[16:0];
      r.rate_y = ry[16:0];
      r.angle_x = acc_x[31:0];
      r.angle_y = acc_y[31:0];
      return r;
   endfunction

   task automatic send_sample(logic [79:0] d);
      while (send_idle > 0 && $urandom_range(99) < send_idle) @(posedge clock);
      req_tvalid <= 1'b1;
      req_tdata <= d;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      expected_words.push_back(predict_sample(d));
      req_tvalid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic write_csr(csr_index_type idx, logic [15:0] v);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= v;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      case (idx)
         CSR_OFFSET_X: ofs_x = longint'($signed(v));
         CSR_OFFSET_Y: ofs_y = longint'($signed(v));
         CSR_OFFSET_Z: ofs_z = longint'($signed(v));
         CSR_PERIOD:   period = longint'(v);
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic drain;
      while (expected_words.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
   endtask

   function automatic logic [15:0] rand_field();
      case ($urandom_range(5))
         0: return 16'h8000;
         1: return 16'h7fff;
         2: return 16'($urandom_range(600)) - 16'd300;
         default: return 16'($urandom);
      endcase
   endfunction

   // sample of random fields with an occasional extreme
   function automatic logic [79:0] rand_sample();
      return {rand_field(), rand_field(), rand_field(), rand_field(), rand_field()};
   endfunction

   task automatic test_directed;
      logic [15:0] ext[4] = '{16'h8000, 16'h7fff, 16'h0000, 16'hffff};
      // zero offsets: zero numerator with zero root, then nonzero numerator over zero root
      write_csr(CSR_OFFSET_X, 16'd0);
      write_csr(CSR_OFFSET_Y, 16'd0);
      write_csr(CSR_OFFSET_Z, 16'd0);
      send_sample({16'd0, 16'd0, 16'd0, 16'd0, 16'd0});
      send_sample({16'd0, 16'd0, 16'd0, 16'd100, 16'd0});
      drain();
      write_csr(CSR_OFFSET_X, 16'd985);
      write_csr(CSR_OFFSET_Y, 16'd221);
      write_csr(CSR_OFFSET_Z, 16'd1615);
      foreach (ext[i]) send_sample({5{ext[i]}});
      send_sample({16'd0, 16'd0, 16'hffe6, 16'hfffd, 16'd16});
      send_sample({16'd0, 16'd0, 16'hffe6, 16'd100, 16'd16});
      send_sample({16'd5, 16'hfffb, 16'hff00, 16'd50, 16'hff00});
      send_sample({16'd7, 16'd9, 16'hfc00, 16'hfff0, 16'd200});
      send_sample({16'h1234, 16'hedcb, 16'hff00, 16'd0, 16'd0});
      send_sample({16'h5555, 16'haaaa, 16'h0400, 16'h0400, 16'h0400});
      drain();
   endtask

   task automatic test_saturation;
      write_csr(CSR_PERIOD, 16'hffff);
      repeat (16) send_sample({16'h7fff, 16'h8000, 16'd100, 16'd50, 16'd20});
      repeat (32) send_sample({16'h8000, 16'h7fff, 16'hff00, 16'd40, 16'd30});
      drain();
      write_csr(CSR_PERIOD, 16'd0);
      repeat (4) send_sample(rand_sample());
      drain();
   endtask

   task automatic test_random_phase(int n, int idle, int stall);
      send_idle = idle;
      recv_stall = stall;
      write_csr(CSR_OFFSET_X, rand_field());
      write_csr(CSR_OFFSET_Y, rand_field());
      write_csr(CSR_OFFSET_Z, rand_field());
      write_csr(CSR_PERIOD, $urandom_range(3) == 0 ? 16'hffff : 16'($urandom));
      repeat (n) send_sample(rand_sample());
      drain();
   endtask

   task automatic test_backpressure;
      send_idle = 0;
      recv_stall = 0;
      hold_off = 600;
      repeat (6) send_sample(rand_sample());
      drain();
   endtask

   // receiver: random stalls and a counted hold-off
   always @(posedge clock) begin
      if (hold_off > 0) begin
         hold_off <= hold_off - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_stall);
      end
   end

   always @(posedge clock) begin
      imu_result_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata[129:0];
         if (expected_words.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected word %h", got);
         end else begin
            want = expected_words.pop_front();
            if (got !== want || rsp_tdata[135:130] !== 6'd0) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("mismatch: tilt %0d/%0d rate %0d/%0d angle %0d/%0d",
                     got.tilt_x, got.tilt_y, got.rate_x, got.rate_y, got.angle_x,
                     got.angle_y);
                  $display("  expected tilt %0d/%0d rate %0d/%0d angle %0d/%0d",
                     want.tilt_x, want.tilt_y, want.rate_x, want.rate_y, want.angle_x,
                     want.angle_y);
               end
            end
         end
      end
   end

   initial begin
      ofs_x = 985; ofs_y = 221; ofs_z = 1615; period = 1311;
      acc_x = 0; acc_y = 0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_saturation();
      write_csr(CSR_OFFSET_X, 16'h8000);
      write_csr(CSR_OFFSET_Y, 16'h7fff);
      write_csr(CSR_OFFSET_Z, 16'h8000);
      repeat (6) send_sample(rand_sample());
      drain();
      test_random_phase(160, 0, 0);
      test_random_phase(160, 59, 0);
      test_random_phase(160, 0, 59);
      test_random_phase(100, 16, 16);
      test_backpressure();
      if (mismatches == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

   initial begin
      #5ms;
      $display("FAILURE");
      $finish;
   end

endmodule
